FILE: design/fre_pkg.sv
// ----------------------------------------------------------------------------
// Fresnel reflectance package
// Shared constants, widths and the data bundles that move between the cells.
// ----------------------------------------------------------------------------
package fre_pkg;

    // Fraction bits of the internal fixed-point values.
    localparam int FRAC_BITS = 15;

    // Field widths.
    localparam int IDX_W = 16;
    localparam int COS_W = 16;
    localparam int RES_W = 16;
    localparam int C_W   = 17;

    // Divider cell widths.
    localparam int REM_W = 35;
    localparam int DEN_W = 34;
    localparam int LOW_W = 16;
    localparam int QUO_W = 16;

    // Square-root cell width.
    localparam int SQ_W = 32;

    // Number of cells in each chain.
    localparam int ST2_STEPS  = 15;
    localparam int SQRT_STEPS = 16;
    localparam int RAT_STEPS  = 16;

    // Unity in the internal format and in the Q1.15 result.
    localparam logic [15:0] ONE     = 16'(1 << FRAC_BITS);
    localparam logic [15:0] RES_ONE = 16'd32768;

    // Item context that travels beside the arithmetic.
    typedef struct packed {
        logic             vld;
        logic             bad;
        logic             tir;
        logic [IDX_W-1:0] ni;
        logic [IDX_W-1:0] no;
        logic [C_W-1:0]   c;
    } side_t;

    // State of one restoring-division step.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [LOW_W-1:0] low;
        logic [QUO_W-1:0] quo;
    } div_t;

    // State of one square-root step.
    typedef struct packed {
        logic [SQ_W-1:0] v;
        logic [SQ_W-1:0] root;
        logic [SQ_W-1:0] sb;
    } sqrt_t;

endpackage

FILE: design/dielectric_fresnel_reflectance.sv
// ----------------------------------------------------------------------------
// Dielectric Fresnel reflectance
// Unpolarized reflectance of a dielectric boundary, fully pipelined.
// ----------------------------------------------------------------------------
// The block takes one item per cycle while the output is not held up. The
// pipeline is made of the cell chains: 15 division cells for the squared
// transmitted sine, 16 square-root cells for the transmitted cosine and 16
// division cells for each of the two amplitude ratios, plus seven stages for the
// multipliers, the compare and the output register. The whole pipeline moves
// forward whenever the output register is empty or its transfer completes.
// A negative cosine swaps the indices. A zero index returns 1.0 with
// bad_index set; total internal reflection returns 1.0 with total_reflection
// set.
module dielectric_fresnel_reflectance (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // index_incident, index_other, cos_incidence
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,  // reflectance
    output logic [1:0]  m_tuser   // total_reflection, bad_index
);

    localparam fre_pkg::side_t SIDE_IDLE = '0;

    logic adv;

    // Front stages.
    logic [fre_pkg::COS_W-1:0] craw;
    logic [fre_pkg::C_W-1:0]   cmag;
    fre_pkg::side_t            s1_side_reg;
    fre_pkg::side_t            s2_side_reg;
    fre_pkg::side_t            s3_side_reg;
    logic [17:0]               c2_reg;
    logic [31:0]               ni2_reg;
    logic [31:0]               no2_reg;
    logic [31:0]               no2_s3_reg;
    logic [47:0]               p_reg;
    logic [33:0]               c_sq;
    logic [15:0]               si2;

    // Chains.
    fre_pkg::div_t  dch   [0:fre_pkg::ST2_STEPS];
    fre_pkg::side_t dside [0:fre_pkg::ST2_STEPS];
    fre_pkg::sqrt_t qch   [0:fre_pkg::SQRT_STEPS];
    fre_pkg::side_t qside [0:fre_pkg::SQRT_STEPS];
    fre_pkg::div_t  sch   [0:fre_pkg::RAT_STEPS];
    fre_pkg::div_t  pch   [0:fre_pkg::RAT_STEPS];
    fre_pkg::side_t rside [0:fre_pkg::RAT_STEPS];

    // Back stages.
    logic [15:0]    ct;
    logic [16:0]    one_m_st2;
    logic [32:0]    x_reg;
    logic [32:0]    y_reg;
    logic [32:0]    xp_reg;
    logic [32:0]    yp_reg;
    fre_pkg::side_t pr_side_reg;
    logic [33:0]    num_s_reg;
    logic [33:0]    den_s_reg;
    logic [33:0]    num_p_reg;
    logic [33:0]    den_p_reg;
    fre_pkg::side_t nd_side_reg;
    logic [16:0]    rs2_reg;
    logic [16:0]    rp2_reg;
    fre_pkg::side_t sq_side_reg;
    logic [31:0]    rs_sq;
    logic [31:0]    rp_sq;
    logic [17:0]    r_sum;
    logic [15:0]    res;

    // Output register.
    logic        out_vld_reg;
    logic [15:0] out_data_reg;
    logic [1:0]  out_user_reg;

    // The pipeline advances unless a finished result is still waiting.
    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;

    // Cosine magnitude, moved from Q2.14 to the internal format.
    assign craw = s_tdata[47:32];
    always_comb
    begin
        if (craw[fre_pkg::COS_W-1])
        begin
            cmag = 17'h10000 - {1'b0, craw};
        end
        else
        begin
            cmag = {1'b0, craw};
        end
    end

    // Stage one: swap on a negative cosine and flag a zero index.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_side_reg <= SIDE_IDLE;
        end
        else if (adv)
        begin
            s1_side_reg.vld <= s_tvalid;
            s1_side_reg.bad <= (s_tdata[15:0] == '0) || (s_tdata[31:16] == '0);
            s1_side_reg.tir <= 1'b0;
            s1_side_reg.ni  <= craw[fre_pkg::COS_W-1] ? s_tdata[31:16] : s_tdata[15:0];
            s1_side_reg.no  <= craw[fre_pkg::COS_W-1] ? s_tdata[15:0] : s_tdata[31:16];
            s1_side_reg.c   <= {cmag[fre_pkg::C_W-2:0], 1'b0};
        end
    end

    // Stage two: squares of the cosine and of both indices.
    assign c_sq = {17'b0, s1_side_reg.c} * {17'b0, s1_side_reg.c};
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_side_reg <= SIDE_IDLE;
        end
        else if (adv)
        begin
            s2_side_reg <= s1_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg  <= c_sq[32:fre_pkg::FRAC_BITS];
            ni2_reg <= {16'b0, s1_side_reg.ni} * {16'b0, s1_side_reg.ni};
            no2_reg <= {16'b0, s1_side_reg.no} * {16'b0, s1_side_reg.no};
        end
    end

    // Stage three: squared incident sine times the incident index squared.
    assign si2 = (c2_reg < {2'b0, fre_pkg::ONE}) ? (fre_pkg::ONE - c2_reg[15:0]) : 16'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_side_reg <= SIDE_IDLE;
        end
        else if (adv)
        begin
            s3_side_reg <= s2_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg      <= {16'b0, ni2_reg} * {32'b0, si2};
            no2_s3_reg <= no2_reg;
        end
    end

    // Total internal reflection test and the seed of the first divider chain.
    always_comb
    begin
        dside[0]     = s3_side_reg;
        dside[0].tir = (p_reg >= {1'b0, no2_s3_reg, 15'b0});
        dch[0].rem   = {1'b0, p_reg[47:14]};
        dch[0].den   = {2'b0, no2_s3_reg};
        dch[0].low   = {p_reg[13:0], 2'b0};
        dch[0].quo   = '0;
    end

    // Division chain for the squared transmitted sine.
    for (genvar k = 0; k < fre_pkg::ST2_STEPS; k++)
    begin : g_st2
        fre_div_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (dch[k]),
            .d_out (dch[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dside[k+1] <= SIDE_IDLE;
            end
            else if (adv)
            begin
                dside[k+1] <= dside[k];
            end
        end
    end

    // Seed of the square-root chain: (1 - sin_t^2) in the internal format.
    assign one_m_st2 = {1'b0, fre_pkg::ONE} -
                       {2'b0, dch[fre_pkg::ST2_STEPS].quo[14:0]};
    always_comb
    begin
        qside[0]   = dside[fre_pkg::ST2_STEPS];
        qch[0].v    = {one_m_st2[16:0], 15'b0};
        qch[0].root = '0;
        qch[0].sb   = 32'h4000_0000;
    end

    // Square-root chain for the transmitted cosine.
    for (genvar k = 0; k < fre_pkg::SQRT_STEPS; k++)
    begin : g_sqrt
        fre_sqrt_cell u_cell (
            .clk   (clk),
            .en    (adv),
            .q_in  (qch[k]),
            .q_out (qch[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                qside[k+1] <= SIDE_IDLE;
            end
            else if (adv)
            begin
                qside[k+1] <= qside[k];
            end
        end
    end

    assign ct = qch[fre_pkg::SQRT_STEPS].root[15:0];

    // Products of indices and cosines.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pr_side_reg <= SIDE_IDLE;
        end
        else if (adv)
        begin
            pr_side_reg <= qside[fre_pkg::SQRT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg  <= {17'b0, qside[fre_pkg::SQRT_STEPS].ni} *
                      {16'b0, qside[fre_pkg::SQRT_STEPS].c};
            y_reg  <= {17'b0, qside[fre_pkg::SQRT_STEPS].no} * {17'b0, ct};
            xp_reg <= {17'b0, qside[fre_pkg::SQRT_STEPS].no} *
                      {16'b0, qside[fre_pkg::SQRT_STEPS].c};
            yp_reg <= {17'b0, qside[fre_pkg::SQRT_STEPS].ni} * {17'b0, ct};
        end
    end

    // Numerators and denominators of both amplitude ratios.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nd_side_reg <= SIDE_IDLE;
        end
        else if (adv)
        begin
            nd_side_reg <= pr_side_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_s_reg <= (x_reg > y_reg) ? {1'b0, x_reg - y_reg} : {1'b0, y_reg - x_reg};
            den_s_reg <= {1'b0, x_reg} + {1'b0, y_reg};
            num_p_reg <= (xp_reg > yp_reg) ? {1'b0, xp_reg - yp_reg} : {1'b0, yp_reg - xp_reg};
            den_p_reg <= {1'b0, xp_reg} + {1'b0, yp_reg};
        end
    end

    // Seeds of the two ratio chains.
    always_comb
    begin
        rside[0]   = nd_side_reg;
        sch[0].rem = {1'b0, num_s_reg};
        sch[0].den = den_s_reg;
        sch[0].low = '0;
        sch[0].quo = '0;
        pch[0].rem = {1'b0, num_p_reg};
        pch[0].den = den_p_reg;
        pch[0].low = '0;
        pch[0].quo = '0;
    end

    // Division chains for the perpendicular and parallel ratios.
    for (genvar k = 0; k < fre_pkg::RAT_STEPS; k++)
    begin : g_rat
        fre_div_cell u_s_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (sch[k]),
            .d_out (sch[k+1])
        );

        fre_div_cell u_p_cell (
            .clk   (clk),
            .en    (adv),
            .d_in  (pch[k]),
            .d_out (pch[k+1])
        );

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rside[k+1] <= SIDE_IDLE;
            end
            else if (adv)
            begin
                rside[k+1] <= rside[k];
            end
        end
    end

    // Squares of both ratios.
    assign rs_sq = {16'b0, sch[fre_pkg::RAT_STEPS].quo} * {16'b0, sch[fre_pkg::RAT_STEPS].quo};
    assign rp_sq = {16'b0, pch[fre_pkg::RAT_STEPS].quo} * {16'b0, pch[fre_pkg::RAT_STEPS].quo};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_side_reg <= SIDE_IDLE;
        end
        else if (adv)
        begin
            sq_side_reg <= rside[fre_pkg::RAT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rs2_reg <= rs_sq[31:fre_pkg::FRAC_BITS];
            rp2_reg <= rp_sq[31:fre_pkg::FRAC_BITS];
        end
    end

    // Mean of the squares, saturated, with the special cases forced to 1.0.
    assign r_sum = {1'b0, rs2_reg} + {1'b0, rp2_reg};
    always_comb
    begin
        if (sq_side_reg.bad || sq_side_reg.tir || (r_sum[17:1] > {1'b0, fre_pkg::RES_ONE}))
        begin
            res = fre_pkg::RES_ONE;
        end
        else
        begin
            res = r_sum[16:1];
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= sq_side_reg.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= res;
            out_user_reg <= {sq_side_reg.bad, sq_side_reg.tir && !sq_side_reg.bad};
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    // Total internal reflection always reports unity.
    a_tir_one: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == fre_pkg::RES_ONE))
        else $error("total reflection without unit reflectance");

    // A bad index reports unity and never total reflection.
    a_bad_one: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1]) |-> (!m_tuser[0] && (m_tdata == fre_pkg::RES_ONE)))
        else $error("bad index result malformed");

    // The result never exceeds unity.
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata <= fre_pkg::RES_ONE))
        else $error("reflectance above one");

endmodule

FILE: design/fre_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// One restoring-division step: compare, subtract, then shift in the next bit.
// ----------------------------------------------------------------------------
module fre_div_cell (
    input  logic          clk,
    input  logic          en,
    input  fre_pkg::div_t d_in,
    output fre_pkg::div_t d_out
);

    logic                      ge;
    logic [fre_pkg::REM_W-1:0] diff;
    fre_pkg::div_t             d_next;

    // Take one quotient bit and bring down the next dividend bit.
    always_comb
    begin
        ge           = (d_in.rem >= {1'b0, d_in.den});
        diff         = ge ? (d_in.rem - {1'b0, d_in.den}) : d_in.rem;
        d_next.rem   = {diff[fre_pkg::REM_W-2:0], d_in.low[fre_pkg::LOW_W-1]};
        d_next.den   = d_in.den;
        d_next.low   = {d_in.low[fre_pkg::LOW_W-2:0], 1'b0};
        d_next.quo   = {d_in.quo[fre_pkg::QUO_W-2:0], ge};
    end

    // Hand the step result to the next cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_out <= d_next;
        end
    end

endmodule

FILE: design/fre_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square-root cell
// One step of the digit-by-digit floor square root, two radicand bits a step.
// ----------------------------------------------------------------------------
module fre_sqrt_cell (
    input  logic           clk,
    input  logic           en,
    input  fre_pkg::sqrt_t q_in,
    output fre_pkg::sqrt_t q_out
);

    logic [fre_pkg::SQ_W-1:0] trial;
    fre_pkg::sqrt_t           q_next;

    // Try the current bit and keep it when the remainder allows.
    always_comb
    begin
        trial = q_in.root + q_in.sb;
        if (q_in.v >= trial)
        begin
            q_next.v    = q_in.v - trial;
            q_next.root = (q_in.root >> 1) + q_in.sb;
        end
        else
        begin
            q_next.v    = q_in.v;
            q_next.root = q_in.root >> 1;
        end
        q_next.sb = q_in.sb >> 2;
    end

    // Hand the step result to the next cell.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q_out <= q_next;
        end
    end

endmodule
